// ===== rtl/ioir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioir_pkg
// Types, register codes and constants for the I/O interrupt redirector.
// ----------------------------------------------------------------------------
package ioir_pkg;

  // number of interrupt input lines
  localparam int NUM_PINS  = 24;
  localparam int PIN_W     = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int TBL_WORDS = 2 * NUM_PINS;
  localparam int TBL_AW    = PIN_W + 1;

  // operation codes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_RAISE = 3'd2;
  localparam logic [2:0] OP_LOWER = 3'd3;
  localparam logic [2:0] OP_EOI   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_MSG  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // register windows and index values
  localparam logic [7:0] WIN_INDEX = 8'h00;
  localparam logic [7:0] WIN_DATA  = 8'h01;
  localparam logic [7:0] SEL_ID    = 8'h00;
  localparam logic [7:0] SEL_VER   = 8'h01;
  localparam logic [7:0] SEL_TBL   = 8'h10;

  // redirection entry low word bits
  localparam int BIT_MASKED = 16;
  localparam int BIT_LEVEL  = 15;
  localparam int BIT_RIRR   = 14;
  localparam int BIT_POL    = 13;

  localparam logic [31:0] LO_RESET    = 32'h0001_0000;
  localparam logic [31:0] VERSION_REG = 32'h0000_0011 | (32'(NUM_PINS - 1) << 16);

  // delivery modes that are rewritten
  localparam logic [2:0] DM_LOWEST     = 3'd1;
  localparam logic [2:0] DM_LOWEST_OUT = 3'd3;
  localparam logic [2:0] DM_EXTINT     = 3'd7;

  // legacy line that stands for line 0
  localparam logic [4:0] PIN_ZERO_ALIAS = 5'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] address_offset;
    logic [31:0] write_data;
    logic [4:0]  pin;
    logic [7:0]  eoi_vector;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [7:0]  vector;
    logic [2:0]  delivery_type;
    logic        level_triggered;
    logic        vector_from_pic;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_DATA,
    S_WR_CMP,
    S_PIN,
    S_EOI,
    S_SCAN_RD,
    S_SCAN,
    S_FLUSH
  } state_t;

endpackage

// ===== rtl/io_interrupt_redirector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_interrupt_redirector_core
// I/O interrupt redirector: index/data register window, 24 pin inputs with
// edge and level handling, remote EOI, and a sequenced redirection table scan.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_stall/in_data carry one request (register read or write, pin
//   raise or lower, remote EOI). out_valid/out_stall/out_data return results:
//   read data, interrupt messages or an unknown-window write error; the final result
//   of a request has last set. cfg_we/cfg_wdata write the enable bit.
// Timing
//   One request at a time; in_stall stays high until the request is finished.
//   Remote EOI walks the table at one entry per cycle. A table write or pin
//   raise that changes state runs a scan, one entry per cycle through the
//   single table memory read port unless it halts for a stalled receiver.
// Reset
//   rst_n clears the registers, the pending and level masks and the entry
//   valid bits; entries never written read as masked. The block is enabled.
// Stall
//   Results go through one output register plus one held message; while the
// receiver stalls and a message is held, the scan halts at the next unmasked pending entry.
// ----------------------------------------------------------------------------
module io_interrupt_redirector_core
  import ioir_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  // control and software-visible state
  state_t                state_r, state_nxt;
  logic                  enabled_r;
  in_item_t              item_r;
  logic [31:0]           index_select_r, index_select_nxt;
  logic [3:0]            apic_id_r, apic_id_nxt;
  logic [NUM_PINS-1:0]   pending_r, pending_nxt;
  logic [NUM_PINS-1:0]   pin_level_r, pin_level_nxt;
  logic [PIN_W-1:0]      cnt_r, cnt_nxt;
  out_item_t             held_r, held_nxt;
  logic                  held_valid_r, held_valid_nxt;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  // table memory and its ports
  logic [31:0]           tbl_mem_r [TBL_WORDS];
  logic [TBL_WORDS-1:0]  tbl_valid_r;
  logic [31:0]           mem_q_r;
  logic                  rd_valid_r;
  logic                  rd_hi_r;
  logic                  mem_re;
  logic [TBL_AW-1:0]     mem_raddr;
  logic                  mem_we;
  logic [TBL_AW-1:0]     mem_waddr;
  logic [31:0]           mem_wdata;
  logic [31:0]           tbl_rdata;

  // decode helpers
  logic                  out_free;
  logic                  push;
  logic                  push_last;
  out_item_t             push_item;
  logic                  accept;
  logic [7:0]            win;
  logic [7:0]            sel;
  logic [7:0]            tbl_off;
  logic                  sel_tbl;
  logic [4:0]            line_map;
  logic                  line_ok;
  logic [PIN_W-1:0]      line_idx;
  logic [31:0]           lo_upd;
  logic                  scan_hit;
  logic                  cnt_last;
  out_item_t             scan_msg;
  out_item_t             rd_msg;
  logic [31:0]           rd_value;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective table word: never-written entries read as their reset value
  assign tbl_rdata = rd_valid_r ? mem_q_r : (rd_hi_r ? 32'h0 : LO_RESET);

  assign win      = item_r.address_offset[11:4];
  assign sel      = index_select_r[7:0];
  assign tbl_off  = sel - SEL_TBL;
  assign sel_tbl  = (sel >= SEL_TBL) && (tbl_off < 8'(TBL_WORDS));
  assign line_map = (item_r.pin == 5'd0) ? PIN_ZERO_ALIAS : item_r.pin;
  assign line_ok  = enabled_r && ({1'b0, line_map} < 6'(NUM_PINS));
  assign line_idx = line_map[PIN_W-1:0];
  assign cnt_last = (cnt_r == PIN_W'(NUM_PINS - 1));

  // message built from the entry under the scan
  assign scan_hit = !tbl_rdata[BIT_MASKED] && pending_r[cnt_r];
  always_comb begin
    scan_msg                 = '0;
    scan_msg.kind            = KIND_MSG;
    scan_msg.vector          = tbl_rdata[7:0];
    scan_msg.delivery_type   = tbl_rdata[10:8];
    scan_msg.level_triggered = tbl_rdata[BIT_LEVEL];
    if (tbl_rdata[10:8] == DM_LOWEST) begin
      scan_msg.delivery_type = DM_LOWEST_OUT;
    end else if (tbl_rdata[10:8] == DM_EXTINT) begin
      scan_msg.vector          = 8'h00;
      scan_msg.vector_from_pic = 1'b1;
    end
  end

  // register read value outside the table
  always_comb begin
    rd_value = 32'h0;
    if (win == WIN_INDEX) begin
      rd_value = index_select_r;
    end else if (win == WIN_DATA) begin
      if (sel == SEL_ID) begin
        rd_value = {4'h0, apic_id_r, 24'h0};
      end else if (sel == SEL_VER) begin
        rd_value = VERSION_REG;
      end
    end
  end

  always_comb begin
    rd_msg      = '0;
    rd_msg.kind = KIND_READ;
    rd_msg.read_data = (state_r == S_RD_DATA) ? tbl_rdata : rd_value;
  end

  // pin raise or lower applied to the entry low word
  always_comb begin
    lo_upd = tbl_rdata;
    if (item_r.operation == OP_RAISE) begin
      lo_upd[BIT_POL] = 1'b1;
      if (tbl_rdata[BIT_LEVEL]) begin
        lo_upd[BIT_RIRR] = 1'b1;
      end
    end else begin
      lo_upd[BIT_POL] = 1'b0;
    end
  end

  // sequencer: next state, memory port and result control
  always_comb begin
    state_nxt        = state_r;
    index_select_nxt = index_select_r;
    apic_id_nxt      = apic_id_r;
    pending_nxt      = pending_r;
    pin_level_nxt    = pin_level_r;
    cnt_nxt          = cnt_r;
    held_nxt         = held_r;
    held_valid_nxt   = held_valid_r;
    mem_re           = 1'b0;
    mem_raddr        = '0;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = '0;
    push             = 1'b0;
    push_last        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        unique case (item_r.operation) inside
          OP_READ: begin
            if (win == WIN_DATA && sel_tbl) begin
              mem_re    = 1'b1;
              mem_raddr = tbl_off[TBL_AW-1:0];
              state_nxt = S_RD_DATA;
            end else begin
              held_nxt       = rd_msg;
              held_valid_nxt = 1'b1;
              state_nxt      = S_FLUSH;
            end
          end
          OP_WRITE: begin
            if (win == WIN_INDEX) begin
              index_select_nxt = item_r.write_data;
            end else if (win == WIN_DATA) begin
              if (sel == SEL_ID) begin
                apic_id_nxt = item_r.write_data[27:24];
              end else if (sel_tbl) begin
                mem_re    = 1'b1;
                mem_raddr = tbl_off[TBL_AW-1:0];
                state_nxt = S_WR_CMP;
              end
            end else begin
              held_nxt       = '0;
              held_nxt.kind  = KIND_ERR;
              held_valid_nxt = 1'b1;
              state_nxt      = S_FLUSH;
            end
          end
          OP_RAISE, OP_LOWER: begin
            if (line_ok) begin
              mem_re    = 1'b1;
              mem_raddr = {line_idx, 1'b0};
              state_nxt = S_PIN;
            end
          end
          OP_EOI: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            cnt_nxt   = '0;
            state_nxt = S_EOI;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RD_DATA: begin
        held_nxt       = rd_msg;
        held_valid_nxt = 1'b1;
        state_nxt      = S_FLUSH;
      end
      S_WR_CMP: begin
        if (tbl_rdata != item_r.write_data) begin
          mem_we    = 1'b1;
          mem_waddr = tbl_off[TBL_AW-1:0];
          mem_wdata = item_r.write_data;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PIN: begin
        mem_we    = 1'b1;
        mem_waddr = {line_idx, 1'b0};
        mem_wdata = lo_upd;
        state_nxt = S_IDLE;
        if (item_r.operation == OP_RAISE) begin
          if (tbl_rdata[BIT_LEVEL]) begin
            if (!tbl_rdata[BIT_RIRR]) begin
              pin_level_nxt[line_idx] = 1'b1;
              pending_nxt[line_idx]   = 1'b1;
              state_nxt               = S_SCAN_RD;
            end
          end else if (!pin_level_r[line_idx]) begin
            pin_level_nxt[line_idx] = 1'b1;
            pending_nxt[line_idx]   = 1'b1;
            state_nxt               = S_SCAN_RD;
          end
        end else begin
          pin_level_nxt[line_idx] = 1'b0;
          if (tbl_rdata[BIT_LEVEL]) begin
            pending_nxt[line_idx] = 1'b0;
          end
        end
      end
      S_EOI: begin
        // write back entry cnt while reading entry cnt + 1
        if (tbl_rdata[7:0] == item_r.eoi_vector) begin
          mem_we              = 1'b1;
          mem_waddr           = {cnt_r, 1'b0};
          mem_wdata           = tbl_rdata;
          mem_wdata[BIT_RIRR] = 1'b0;
        end
        if (cnt_last) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + PIN_W'(1);
          mem_re    = 1'b1;
          mem_raddr = {cnt_r + PIN_W'(1), 1'b0};
        end
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // hold on a hit while the previous message cannot leave
        if (!(scan_hit && held_valid_r && !out_free)) begin
          if (scan_hit) begin
            push           = held_valid_r;
            held_nxt       = scan_msg;
            held_valid_nxt = 1'b1;
            if (!tbl_rdata[BIT_LEVEL]) begin
              pending_nxt[cnt_r] = 1'b0;
            end
          end
          if (cnt_last) begin
            state_nxt = S_FLUSH;
          end else begin
            cnt_nxt   = cnt_r + PIN_W'(1);
            mem_re    = 1'b1;
            mem_raddr = {cnt_r + PIN_W'(1), 1'b0};
          end
        end
      end
      S_FLUSH: begin
        if (!held_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          push_last      = 1'b1;
          held_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // item leaving for the output register
  always_comb begin
    push_item      = held_r;
    push_item.last = push_last;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      enabled_r      <= 1'b1;
      index_select_r <= '0;
      apic_id_r      <= '0;
      pending_r      <= '0;
      pin_level_r    <= '0;
      cnt_r          <= '0;
      held_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      index_select_r <= index_select_nxt;
      apic_id_r      <= apic_id_nxt;
      pending_r      <= pending_nxt;
      pin_level_r    <= pin_level_nxt;
      cnt_r          <= cnt_nxt;
      held_valid_r   <= held_valid_nxt;
      if (cfg_we) begin
        enabled_r <= cfg_wdata;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    held_r <= held_nxt;
    if (push) begin
      out_data_r <= push_item;
    end
  end

  // redirection table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= tbl_mem_r[mem_raddr];
    end
  end

  // per-word valid bits and read-side tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_valid_r <= '0;
      rd_valid_r  <= 1'b0;
      rd_hi_r     <= 1'b0;
    end else begin
      if (mem_we) begin
        tbl_valid_r[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid_r <= tbl_valid_r[mem_raddr];
        rd_hi_r    <= mem_raddr[0];
      end
    end
  end

  // checks
  a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !held_valid_r)
    else $error("message held while idle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_last) |=> (state_r == S_IDLE))
    else $error("final result without return to idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} < (PIN_W + 1)'(NUM_PINS)))
    else $error("entry counter out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (out_free && held_valid_r))
    else $error("result pushed without room or content");

endmodule

// ===== dv/io_redirect_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_redirect_checker
// Watches the request, result and enable ports of the interrupt redirector. It
// keeps its own copy of the registers, masks and redirection table. For each
// accepted request it works out the results owed, and it compares every
// accepted result, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module io_redirect_checker
  import ioir_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output int        fail_count,
  output int        results_due
);

  // copy of the block state
  logic                enable_q;
  logic [31:0]         index_sel;
  logic [3:0]          apic_id_q;
  logic [NUM_PINS-1:0] pend_q;
  logic [NUM_PINS-1:0] line_high_q;
  logic [31:0]         redir_tbl [TBL_WORDS];

  // results of the request being worked out, then the ones still owed
  out_item_t batch [NUM_PINS];
  int        batch_len;
  out_item_t owed_results [$];
  out_item_t owed_head;

  // walk the table in pin order, one message per unmasked pending line
  task automatic scan_table();
    logic [31:0] lo;
    out_item_t   msg;
    for (int i = 0; i < NUM_PINS; i++) begin
      lo = redir_tbl[2 * i];
      if (!lo[BIT_MASKED] && pend_q[i]) begin
        if (!lo[BIT_LEVEL]) pend_q[i] = 1'b0;
        msg = '0;
        msg.kind = KIND_MSG;
        msg.vector = lo[7:0];
        msg.delivery_type = lo[10:8];
        msg.level_triggered = lo[BIT_LEVEL];
        if (lo[10:8] == DM_LOWEST) begin
          msg.delivery_type = DM_LOWEST_OUT;
        end else if (lo[10:8] == DM_EXTINT) begin
          msg.vector = '0;
          msg.vector_from_pic = 1'b1;
        end
        batch[batch_len] = msg;
        batch_len++;
      end
    end
  endtask

  // value seen through the index or data window
  function automatic logic [31:0] register_value(input logic [11:0] addr);
    logic [7:0] win;
    logic [7:0] sel;
    win = addr[11:4];
    sel = index_sel[7:0];
    if (win == WIN_INDEX) return index_sel;
    if (win != WIN_DATA) return '0;
    if (sel == SEL_ID) return {4'h0, apic_id_q, 24'h0};
    if (sel == SEL_VER) return VERSION_REG;
    if (sel >= SEL_TBL && (sel - SEL_TBL) < TBL_WORDS) return redir_tbl[sel - SEL_TBL];
    return '0;
  endfunction

  // apply one request to the copy and queue the results it causes
  task automatic serve_request(input in_item_t req);
    logic [7:0] win;
    logic [7:0] sel;
    logic [4:0] line;
    int         tix;
    out_item_t  res;
    batch_len = 0;
    win = req.address_offset[11:4];
    sel = index_sel[7:0];
    res = '0;
    case (req.operation)
      OP_READ: begin
        res.kind = KIND_READ;
        res.read_data = register_value(req.address_offset);
        batch[0] = res;
        batch_len = 1;
      end
      OP_WRITE: begin
        if (win == WIN_INDEX) begin
          index_sel = req.write_data;
        end else if (win == WIN_DATA) begin
          if (sel == SEL_ID) begin
            apic_id_q = req.write_data[27:24];
          end else if (sel >= SEL_TBL && (sel - SEL_TBL) < TBL_WORDS) begin
            tix = sel - SEL_TBL;
            // an unchanged word does not rescan
            if (redir_tbl[tix] != req.write_data) begin
              redir_tbl[tix] = req.write_data;
              scan_table();
            end
          end
        end else begin
          res.kind = KIND_ERR;
          batch[0] = res;
          batch_len = 1;
        end
      end
      OP_RAISE, OP_LOWER: begin
        line = (req.pin == '0) ? PIN_ZERO_ALIAS : req.pin;
        if (enable_q && line < NUM_PINS) begin
          tix = 2 * line;
          if (req.operation == OP_RAISE) begin
            redir_tbl[tix][BIT_POL] = 1'b1;
            if (redir_tbl[tix][BIT_LEVEL]) begin
              // level line is locked while remote irr is set
              if (!redir_tbl[tix][BIT_RIRR]) begin
                redir_tbl[tix][BIT_RIRR] = 1'b1;
                line_high_q[line] = 1'b1;
                pend_q[line] = 1'b1;
                scan_table();
              end
            end else if (!line_high_q[line]) begin
              pend_q[line] = 1'b1;
              line_high_q[line] = 1'b1;
              scan_table();
            end
          end else begin
            line_high_q[line] = 1'b0;
            redir_tbl[tix][BIT_POL] = 1'b0;
            if (redir_tbl[tix][BIT_LEVEL]) pend_q[line] = 1'b0;
          end
        end
      end
      OP_EOI: begin
        for (int i = 0; i < NUM_PINS; i++) begin
          if (redir_tbl[2 * i][7:0] == req.eoi_vector) redir_tbl[2 * i][BIT_RIRR] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (batch_len > 0) batch[batch_len - 1].last = 1'b1;
    for (int i = 0; i < batch_len; i++) owed_results.push_back(batch[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // results first, then enable writes, then the new request
  always @(posedge clk) begin
    if (!rst_n) begin
      enable_q = 1'b1;
      index_sel = '0;
      apic_id_q = '0;
      pend_q = '0;
      line_high_q = '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        redir_tbl[2 * i] = LO_RESET;
        redir_tbl[2 * i + 1] = '0;
      end
      owed_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result of kind %0d with nothing owed", out_data.kind);
          fail_count++;
        end else begin
          owed_head = owed_results.pop_front();
          check_field("kind", owed_head.kind, out_data.kind);
          check_field("read_data", owed_head.read_data, out_data.read_data);
          check_field("vector", owed_head.vector, out_data.vector);
          check_field("delivery_type", owed_head.delivery_type, out_data.delivery_type);
          check_field("level_triggered", owed_head.level_triggered,
                      out_data.level_triggered);
          check_field("vector_from_pic", owed_head.vector_from_pic,
                      out_data.vector_from_pic);
          check_field("last", owed_head.last, out_data.last);
        end
      end
      if (cfg_we) enable_q = cfg_wdata;
      if (in_valid && !in_stall) serve_request(in_data);
    end
    results_due = owed_results.size();
  end

endmodule

// ===== dv/tb_io_interrupt_redirector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_io_interrupt_redirector_core
// Drives register accesses, pin raises and lowers and remote EOIs into the
// interrupt redirector under random sender gaps and receiver stalls, with the
// enable bit switched between phases. The checker beside the block predicts
// and compares every result; this module only makes requests and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_io_interrupt_redirector_core;
  import ioir_pkg::*;

  localparam int         CYCLE_LIMIT     = 600000;
  localparam int         DRAIN_CYCLES    = 2 * NUM_PINS + 16;
  localparam logic [7:0] SEL_ARB         = 8'h02;
  localparam logic [7:0] SEL_UNUSED      = 8'hFF;
  localparam logic [7:0] WIN_FIRST_OTHER = 8'h02;
  localparam logic [7:0] WIN_LAST        = 8'hFF;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam logic [7:0] VEC_POOL        = 8'h40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;

  int fail_count;
  int results_due;
  int cycle_count = 0;
  int send_gap_pct = 6;
  int recv_stall_pct = 52;

  io_interrupt_redirector_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  io_redirect_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always #4 clk = ~clk;

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_io_interrupt_redirector_core: FAIL");
      $finish;
    end
  end

  // random filler for fields a request does not use
  function automatic in_item_t rand_item();
    in_item_t r;
    r.operation = 3'($urandom_range(7));
    r.address_offset = 12'($urandom_range(4095));
    r.write_data = $urandom;
    r.pin = 5'($urandom_range(31));
    r.eoi_vector = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic logic [11:0] win_addr(input logic [7:0] win);
    return {win, 4'($urandom_range(15))};
  endfunction

  // mostly in-range lines, now and then one above the last pin, up to line 31
  function automatic logic [4:0] rand_line();
    if ($urandom_range(9) == 0) return 5'($urandom_range(31, NUM_PINS));
    return 5'($urandom_range(NUM_PINS - 1));
  endfunction

  function automatic logic [7:0] rand_vector();
    if ($urandom_range(9) < 7) return VEC_POOL + 8'($urandom_range(7));
    return 8'($urandom_range(255));
  endfunction

  // low word of an entry: mostly unmasked, vectors mostly from a small pool
  function automatic logic [31:0] rand_entry_lo();
    logic [31:0] w;
    w = $urandom;
    w[7:0] = rand_vector();
    w[BIT_MASKED] = ($urandom_range(99) < 15);
    w[BIT_RIRR] = ($urandom_range(99) < 5);
    w[BIT_LEVEL] = 1'($urandom_range(1));
    return w;
  endfunction

  // present one request and hold it until accepted
  task automatic send_request(input in_item_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = req;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic reg_write(input logic [11:0] addr, input logic [31:0] data);
    in_item_t r;
    r = rand_item();
    r.operation = OP_WRITE;
    r.address_offset = addr;
    r.write_data = data;
    send_request(r);
  endtask

  task automatic reg_read(input logic [11:0] addr);
    in_item_t r;
    r = rand_item();
    r.operation = OP_READ;
    r.address_offset = addr;
    send_request(r);
  endtask

  task automatic pin_event(input logic [2:0] op, input logic [4:0] line);
    in_item_t r;
    r = rand_item();
    r.operation = op;
    r.pin = line;
    send_request(r);
  endtask

  task automatic remote_eoi(input logic [7:0] vec);
    in_item_t r;
    r = rand_item();
    r.operation = OP_EOI;
    r.eoi_vector = vec;
    send_request(r);
  endtask

  task automatic odd_request(input logic [2:0] op);
    in_item_t r;
    r = rand_item();
    r.operation = op;
    send_request(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // let a request with no result finish as well
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_enable(input logic value);
    settle();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // extremes, every operation and the corner cases
  task automatic directed_requests();
    logic [31:0] ext_lvl;
    ext_lvl = {21'h0, DM_EXTINT, 8'h00};
    ext_lvl[BIT_LEVEL] = 1'b1;
    reg_read(win_addr(WIN_DATA));
    reg_write(win_addr(WIN_DATA), 32'hFFFF_FFFF);
    reg_read(win_addr(WIN_DATA));
    reg_write(win_addr(WIN_INDEX), {24'hFFFFFF, SEL_VER});
    reg_read(win_addr(WIN_DATA));
    reg_write(win_addr(WIN_INDEX), {24'h0, SEL_ARB});
    reg_read(win_addr(WIN_DATA));
    reg_read(win_addr(WIN_INDEX));
    reg_write(win_addr(WIN_LAST), 32'hFFFF_FFFF);
    reg_read(win_addr(WIN_FIRST_OTHER));
    // edge entry on line 2, lowest priority, reached through line 0
    reg_write(win_addr(WIN_INDEX), {24'h0, SEL_TBL + 8'd4});
    reg_write(win_addr(WIN_DATA), {21'h0, DM_LOWEST, 8'hFF});
    pin_event(OP_RAISE, 5'd0);
    pin_event(OP_RAISE, PIN_ZERO_ALIAS);
    pin_event(OP_LOWER, PIN_ZERO_ALIAS);
    // level ExtINT entry on the last line, locked until remote EOI
    reg_write(win_addr(WIN_INDEX), {24'h0, SEL_TBL + 8'(2 * (NUM_PINS - 1))});
    reg_write(win_addr(WIN_DATA), ext_lvl);
    pin_event(OP_RAISE, 5'(NUM_PINS - 1));
    pin_event(OP_RAISE, 5'(NUM_PINS - 1));
    reg_read(win_addr(WIN_DATA));
    remote_eoi(8'h00);
    pin_event(OP_RAISE, 5'(NUM_PINS - 1));
    pin_event(OP_LOWER, 5'(NUM_PINS - 1));
    // a rewrite of the same word
    reg_write(win_addr(WIN_DATA), ext_lvl);
    reg_write(win_addr(WIN_DATA), ext_lvl);
    pin_event(OP_RAISE, 5'd31);
    reg_write(win_addr(WIN_INDEX), {24'h0, SEL_UNUSED});
    reg_read(win_addr(WIN_DATA));
    reg_write(win_addr(WIN_DATA), 32'hFFFF_FFFF);
    odd_request(OP_FIRST_UNUSED);
    odd_request(OP_LAST_UNUSED);
  endtask

  // mostly table programming and pin traffic, some reads and noise
  task automatic random_requests(input int target);
    int          made;
    int          choice;
    logic [7:0]  sel;
    made = 0;
    while (made < target) begin
      choice = $urandom_range(99);
      if (choice < 25) begin
        sel = SEL_TBL + 8'(2 * $urandom_range(NUM_PINS - 1));
        if ($urandom_range(4) == 0) begin
          reg_write(win_addr(WIN_INDEX), {24'($urandom), sel + 8'd1});
          reg_write(win_addr(WIN_DATA), $urandom);
        end else begin
          reg_write(win_addr(WIN_INDEX), {24'($urandom), sel});
          reg_write(win_addr(WIN_DATA), rand_entry_lo());
        end
        made += 2;
      end else if (choice < 50) begin
        pin_event(OP_RAISE, rand_line());
        made++;
      end else if (choice < 63) begin
        pin_event(OP_LOWER, rand_line());
        made++;
      end else if (choice < 72) begin
        remote_eoi(($urandom_range(9) == 0) ? 8'h00 : rand_vector());
        made++;
      end else if (choice < 84) begin
        case ($urandom_range(5))
          0: sel = SEL_ID;
          1: sel = SEL_VER;
          2: sel = SEL_ARB;
          3: sel = 8'($urandom_range(255));
          default: sel = SEL_TBL + 8'($urandom_range(TBL_WORDS - 1));
        endcase
        reg_write(win_addr(WIN_INDEX), {24'($urandom), sel});
        reg_read(win_addr(WIN_DATA));
        if ($urandom_range(1)) reg_read(win_addr(WIN_INDEX));
        else reg_read(win_addr(8'($urandom_range(255, WIN_FIRST_OTHER))));
        made += 3;
      end else if (choice < 88) begin
        reg_write(win_addr(WIN_INDEX), {24'($urandom), SEL_ID});
        reg_write(win_addr(WIN_DATA), $urandom);
        made += 2;
      end else if (choice < 93) begin
        reg_write(win_addr(8'($urandom_range(255, WIN_FIRST_OTHER))), $urandom);
        made++;
      end else begin
        // noise: anything at all, unused operations included
        odd_request(3'($urandom_range(7)));
        made++;
      end
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    set_enable(1'b1);
    directed_requests();

    // sender rarely idle, receiver often stalled
    random_requests(180);
    set_enable(1'b0);
    random_requests(40);
    set_enable(1'b1);

    // sender often idle, receiver rarely stalled
    send_gap_pct = 52;
    recv_stall_pct = 6;
    random_requests(130);

    // neither side idles
    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_requests(130);

    settle();
    if (fail_count == 0) begin
      $display("tb_io_interrupt_redirector_core: PASS");
    end else begin
      $display("tb_io_interrupt_redirector_core: FAIL");
    end
    $finish;
  end

endmodule
